// File: sv/blg_pkg.sv
// Shared constants and types for the battery level gauge.
package blg_pkg;

	localparam int ADC_BITS_DEF = 12;
	localparam int VOLT_W = 10;
	localparam int LEVEL_W = 2;
	localparam int COUNT_W = 4;
	localparam int CFG_DATA_W = 10;
	localparam int CFG_IDX_W = 2;

	// Full scale of the converter corresponds to 6.00 V, that is 600 units of 10 mV.
	localparam int VOLT_SCALE = 600;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [LEVEL_W-1:0] LEVEL_FULL = 2'd3;
	localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 2'd2;
	localparam logic [LEVEL_W-1:0] LEVEL_LOW = 2'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_EMPTY = 2'd0;

	// Thresholds for the stopped-motor level choice, in 10 mV.
	localparam logic [VOLT_W-1:0] STOP_L3_UP = 10'd390;
	localparam logic [VOLT_W-1:0] STOP_L3_HOLD = 10'd385;
	localparam logic [VOLT_W-1:0] STOP_L2_UP = 10'd370;
	localparam logic [VOLT_W-1:0] STOP_L2_HOLD = 10'd360;
	localparam logic [VOLT_W-1:0] STOP_L1_UP = 10'd355;
	localparam logic [VOLT_W-1:0] STOP_L1_HOLD = 10'd350;

	// Step-down thresholds while the motor runs, in 10 mV.
	localparam logic [VOLT_W-1:0] RUN_DOWN_3 = 10'd380;
	localparam logic [VOLT_W-1:0] RUN_DOWN_2 = 10'd355;
	localparam logic [VOLT_W-1:0] RUN_DOWN_1 = 10'd345;

	localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 4'd4;
	localparam logic [VOLT_W-1:0] LOW_STOP_RESET = 10'd340;
	localparam logic [VOLT_W-1:0] LOW_RUN_RESET = 10'd335;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE = 2'd0,
		CFG_LOW_STOP = 2'd1,
		CFG_LOW_RUN  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] committed;
		logic [LEVEL_W-1:0] candidate;
		logic [LEVEL_W-1:0] prev_candidate;
		logic [COUNT_W-1:0] repeat_cnt;
		logic               low_power;
		logic               warning;
	} gauge_state_t;

endpackage

// File: sv/blg_in_if.sv
// Sample channel: converter reading and motor state with valid/ready.
interface blg_in_if #(
	parameter int ADC_BITS = blg_pkg::ADC_BITS_DEF
);
	logic                valid;
	logic                ready;
	logic [ADC_BITS-1:0] adc_sample;
	logic                motor_running;

	modport source (output valid, output adc_sample, output motor_running, input ready);
	modport sink (input valid, input adc_sample, input motor_running, output ready);
endinterface

// File: sv/blg_out_if.sv
// Result channel: gauge level, flags and scaled voltage with valid/ready.
interface blg_out_if;
	logic                         valid;
	logic                         ready;
	logic [blg_pkg::LEVEL_W-1:0]  battery_level;
	logic                         low_power;
	logic                         low_warning;
	logic [blg_pkg::VOLT_W-1:0]   battery_voltage;

	modport source (output valid, output battery_level, output low_power,
		output low_warning, output battery_voltage, input ready);
	modport sink (input valid, input battery_level, input low_power,
		input low_warning, input battery_voltage, output ready);
endinterface

// File: sv/blg_scale.sv
// Converts a raw converter reading to 10 mV units: floor(sample * 600 / full scale).
module blg_scale #(
	parameter int ADC_BITS = blg_pkg::ADC_BITS_DEF
) (
	input  logic [ADC_BITS-1:0]        adc_sample,
	output logic [blg_pkg::VOLT_W-1:0] battery_voltage
);
	localparam int VW = blg_pkg::VOLT_W;
	localparam longint unsigned FULL = (64'd1 << ADC_BITS) - 64'd1;
	localparam int SHIFT = ADC_BITS + VW;
	localparam longint unsigned RECIP =
		(64'(blg_pkg::VOLT_SCALE) << SHIFT) / FULL;
	localparam int RW = $clog2(RECIP + 64'd1);
	localparam int PW = ADC_BITS + RW;
	localparam int SW = ADC_BITS + VW;

	logic [PW-1:0] prod;
	logic [VW-1:0] q_est;
	logic [SW-1:0] scaled;
	logic [SW-1:0] back;
	logic [SW-1:0] rem;

	// The truncated reciprocal leaves the estimate at most one below the true
	// quotient; the remainder check adds that one back.
	always_comb begin
		prod = PW'(adc_sample) * PW'(RECIP);
		q_est = VW'(prod >> SHIFT);
		scaled = SW'(adc_sample) * SW'(blg_pkg::VOLT_SCALE);
		back = (SW'(q_est) << ADC_BITS) - SW'(q_est);
		rem = scaled - back;
		battery_voltage = q_est + VW'(rem >= SW'(FULL));
	end
endmodule

// File: sv/blg_track.sv
// Next-state logic of the gauge: low-power test, candidate choice and debounce.
module blg_track (
	input  blg_pkg::gauge_state_t        cur,
	input  logic [blg_pkg::VOLT_W-1:0]   voltage,
	input  logic                         running,
	input  logic [blg_pkg::COUNT_W-1:0]  debounce_limit,
	input  logic [blg_pkg::VOLT_W-1:0]   low_stop_threshold,
	input  logic [blg_pkg::VOLT_W-1:0]   low_run_threshold,
	output blg_pkg::gauge_state_t        nxt
);
	logic [blg_pkg::VOLT_W-1:0]  thr;
	logic [blg_pkg::LEVEL_W-1:0] stop_pick;
	logic [blg_pkg::LEVEL_W-1:0] cand;

	always_comb begin
		if (voltage > blg_pkg::STOP_L3_UP ||
			(cur.committed == blg_pkg::LEVEL_FULL && voltage > blg_pkg::STOP_L3_HOLD)) begin
			stop_pick = blg_pkg::LEVEL_FULL;
		end else if (voltage > blg_pkg::STOP_L2_UP ||
			(cur.committed > blg_pkg::LEVEL_LOW && voltage > blg_pkg::STOP_L2_HOLD)) begin
			stop_pick = blg_pkg::LEVEL_HIGH;
		end else if (voltage > blg_pkg::STOP_L1_UP ||
			(cur.committed > blg_pkg::LEVEL_EMPTY && voltage > blg_pkg::STOP_L1_HOLD)) begin
			stop_pick = blg_pkg::LEVEL_LOW;
		end else begin
			stop_pick = blg_pkg::LEVEL_EMPTY;
		end
	end

	always_comb begin
		nxt = cur;
		thr = running ? low_run_threshold : low_stop_threshold;

		// The set test looks at the level committed before this sample.
		if (cur.committed == blg_pkg::LEVEL_EMPTY && !cur.low_power && voltage < thr) begin
			nxt.low_power = 1'b1;
		end

		// While running, the candidate only steps down, and otherwise holds.
		cand = cur.candidate;
		if (!running) begin
			cand = stop_pick;
		end else if (cur.committed == blg_pkg::LEVEL_FULL && voltage < blg_pkg::RUN_DOWN_3) begin
			cand = blg_pkg::LEVEL_HIGH;
		end else if (cur.committed == blg_pkg::LEVEL_HIGH && voltage <= blg_pkg::RUN_DOWN_2) begin
			cand = blg_pkg::LEVEL_LOW;
		end else if (cur.committed == blg_pkg::LEVEL_LOW && voltage <= blg_pkg::RUN_DOWN_1) begin
			cand = blg_pkg::LEVEL_EMPTY;
		end
		nxt.candidate = cand;

		if (cur.prev_candidate != cand) begin
			nxt.prev_candidate = cand;
			nxt.repeat_cnt = '0;
		end else if (cur.repeat_cnt > debounce_limit) begin
			nxt.repeat_cnt = '0;
			nxt.committed = cand;
			if (cand != blg_pkg::LEVEL_EMPTY) begin
				nxt.low_power = 1'b0;
			end
			nxt.warning = (cand == blg_pkg::LEVEL_EMPTY);
		end else if (cur.repeat_cnt != blg_pkg::COUNT_MAX) begin
			nxt.repeat_cnt = cur.repeat_cnt + 1'b1;
		end
	end
endmodule

// File: sv/battery_level_gauge_top.sv
// Battery level gauge: scaled voltage, debounced level with hysteresis and low-power flags.
// Each sample beat passes an input register and a result register, so a result is offered once
// its sample has left the input register, and one sample is accepted every cycle when the result
// side keeps up. The whole update (scale multiply, level choice, debounce) sits in the single
// stage between those registers, with the gauge state written as each result is registered.
// Configuration writes go to three registers: debounce limit, stopped and running low-power
// thresholds, and should be made while no sample is in flight.
module battery_level_gauge_top #(
	parameter int ADC_BITS = blg_pkg::ADC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	blg_in_if.sink                             samples,
	blg_out_if.source                          levels,
	input  logic                               cfg_we,
	input  logic [blg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [blg_pkg::CFG_DATA_W-1:0]     cfg_data
);
	logic                            valid_s1;
	logic [ADC_BITS-1:0]             adc_s1;
	logic                            run_s1;
	logic                            out_valid_q;
	logic                            advance;
	logic [blg_pkg::VOLT_W-1:0]      voltage;
	blg_pkg::gauge_state_t           state_q;
	blg_pkg::gauge_state_t           state_next;
	logic [blg_pkg::COUNT_W-1:0]     debounce_q;
	logic [blg_pkg::VOLT_W-1:0]      low_stop_q;
	logic [blg_pkg::VOLT_W-1:0]      low_run_q;
	logic [blg_pkg::LEVEL_W-1:0]     level_q;
	logic                            low_power_q;
	logic                            warning_q;
	logic [blg_pkg::VOLT_W-1:0]      voltage_q;

	assign advance = valid_s1 && (!out_valid_q || levels.ready);
	assign samples.ready = !valid_s1 || advance;

	blg_scale #(.ADC_BITS(ADC_BITS)) u_scale (
		.adc_sample      (adc_s1),
		.battery_voltage (voltage)
	);

	blg_track u_track (
		.cur                (state_q),
		.voltage            (voltage),
		.running            (run_s1),
		.debounce_limit     (debounce_q),
		.low_stop_threshold (low_stop_q),
		.low_run_threshold  (low_run_q),
		.nxt                (state_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			state_q <= '{committed: blg_pkg::LEVEL_FULL, candidate: blg_pkg::LEVEL_FULL,
				prev_candidate: blg_pkg::LEVEL_FULL, repeat_cnt: '0,
				low_power: 1'b0, warning: 1'b0};
			debounce_q <= blg_pkg::DEBOUNCE_RESET;
			low_stop_q <= blg_pkg::LOW_STOP_RESET;
			low_run_q <= blg_pkg::LOW_RUN_RESET;
		end else begin
			if (samples.ready) begin
				valid_s1 <= samples.valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				state_q <= state_next;
			end else if (levels.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					blg_pkg::CFG_DEBOUNCE: debounce_q <= cfg_data[blg_pkg::COUNT_W-1:0];
					blg_pkg::CFG_LOW_STOP: low_stop_q <= cfg_data[blg_pkg::VOLT_W-1:0];
					blg_pkg::CFG_LOW_RUN: low_run_q <= cfg_data[blg_pkg::VOLT_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// Payload registers load only with their beat and need no reset.
	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			adc_s1 <= samples.adc_sample;
			run_s1 <= samples.motor_running;
		end
		if (advance) begin
			level_q <= state_next.committed;
			low_power_q <= state_next.low_power;
			warning_q <= state_next.warning;
			voltage_q <= voltage;
		end
	end

	assign levels.valid = out_valid_q;
	assign levels.battery_level = level_q;
	assign levels.low_power = low_power_q;
	assign levels.low_warning = warning_q;
	assign levels.battery_voltage = voltage_q;
endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the battery level gauge: random and directed samples, scored results.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ADC_BITS = blg_pkg::ADC_BITS_DEF;
	localparam int FULL_SCALE = (1 << ADC_BITS) - 1;
	localparam int MAX_VOLTS = 600;
	localparam int CYCLE_LIMIT = 500000;
	localparam int LATENCY_PAD = 4;
	localparam int HOLD_CYCLES = 150;

	// Level choice thresholds in 10 mV.
	localparam int STOP_3_UP = 390;
	localparam int STOP_3_KEEP = 385;
	localparam int STOP_2_UP = 370;
	localparam int STOP_2_KEEP = 360;
	localparam int STOP_1_UP = 355;
	localparam int STOP_1_KEEP = 350;
	localparam int RUN_STEP_3 = 380;
	localparam int RUN_STEP_2 = 355;
	localparam int RUN_STEP_1 = 345;

	typedef struct packed {
		logic [ADC_BITS-1:0] adc;
		logic                motor;
	} sample_t;

	typedef struct packed {
		logic [blg_pkg::LEVEL_W-1:0] level;
		logic                        low_power;
		logic                        warning;
		logic [blg_pkg::VOLT_W-1:0]  volts;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [blg_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [blg_pkg::CFG_DATA_W-1:0] cfg_data;

	blg_in_if #(.ADC_BITS(ADC_BITS)) sample_bus ();
	blg_out_if level_bus ();

	battery_level_gauge_top #(.ADC_BITS(ADC_BITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(sample_bus),
		.levels(level_bus),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Gauge predictor: configuration and state as they stand after reset.
	logic [blg_pkg::COUNT_W-1:0] gauge_debounce = 4'd4;
	logic [blg_pkg::VOLT_W-1:0] gauge_stop_thr = 10'd340;
	logic [blg_pkg::VOLT_W-1:0] gauge_run_thr = 10'd335;
	logic [blg_pkg::LEVEL_W-1:0] gauge_committed = blg_pkg::LEVEL_FULL;
	logic [blg_pkg::LEVEL_W-1:0] gauge_candidate = blg_pkg::LEVEL_FULL;
	logic [blg_pkg::LEVEL_W-1:0] gauge_prev = blg_pkg::LEVEL_FULL;
	logic [blg_pkg::COUNT_W-1:0] gauge_repeat = '0;
	logic gauge_low_power = 1'b0;
	logic gauge_warning = 1'b0;

	sample_t pending_samples[$];
	reading_t expected_readings[$];

	int failures = 0;
	int cycle_count = 0;
	int tx_gap = 0;
	int rx_gap = 0;
	int rx_hold = 0;
	int hold_seen = 0;
	int hold_ticket = 0;
	bit tx_idle_off = 1'b0;
	bit rx_idle_off = 1'b0;

	function automatic reading_t gauge_step(sample_t s);
		int unsigned adc;
		int unsigned volts;
		int unsigned thr;
		reading_t r;
		adc = 32'(s.adc);
		volts = (adc * MAX_VOLTS) / FULL_SCALE;

		// The low-power test looks at the level committed before this sample.
		if (gauge_committed == blg_pkg::LEVEL_EMPTY && !gauge_low_power) begin
			thr = 32'(s.motor ? gauge_run_thr : gauge_stop_thr);
			if (volts < thr)
				gauge_low_power = 1'b1;
		end

		if (!s.motor) begin
			if (volts > STOP_3_UP || (gauge_committed > 2 && volts > STOP_3_KEEP))
				gauge_candidate = blg_pkg::LEVEL_FULL;
			else if (volts > STOP_2_UP || (gauge_committed > 1 && volts > STOP_2_KEEP))
				gauge_candidate = blg_pkg::LEVEL_HIGH;
			else if (volts > STOP_1_UP || (gauge_committed > 0 && volts > STOP_1_KEEP))
				gauge_candidate = blg_pkg::LEVEL_LOW;
			else
				gauge_candidate = blg_pkg::LEVEL_EMPTY;
		end else if (gauge_committed == blg_pkg::LEVEL_FULL && volts < RUN_STEP_3) begin
			gauge_candidate = blg_pkg::LEVEL_HIGH;
		end else if (gauge_committed == blg_pkg::LEVEL_HIGH && volts <= RUN_STEP_2) begin
			gauge_candidate = blg_pkg::LEVEL_LOW;
		end else if (gauge_committed == blg_pkg::LEVEL_LOW && volts <= RUN_STEP_1) begin
			gauge_candidate = blg_pkg::LEVEL_EMPTY;
		end

		if (gauge_prev != gauge_candidate) begin
			gauge_prev = gauge_candidate;
			gauge_repeat = '0;
		end else if (gauge_repeat > gauge_debounce) begin
			gauge_repeat = '0;
			gauge_committed = gauge_candidate;
			if (gauge_committed != blg_pkg::LEVEL_EMPTY)
				gauge_low_power = 1'b0;
			gauge_warning = (gauge_committed == blg_pkg::LEVEL_EMPTY);
		end else if (gauge_repeat != blg_pkg::COUNT_MAX) begin
			gauge_repeat = gauge_repeat + 1'b1;
		end

		r.level = gauge_committed;
		r.low_power = gauge_low_power;
		r.warning = gauge_warning;
		r.volts = volts[blg_pkg::VOLT_W-1:0];
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Lowest reading that scales to the given voltage, plus a jitter that keeps the voltage.
	function automatic logic [ADC_BITS-1:0] adc_for(int volts);
		int a;
		a = (volts * FULL_SCALE + MAX_VOLTS - 1) / MAX_VOLTS + $urandom_range(0, 5);
		if (a > FULL_SCALE)
			a = FULL_SCALE;
		return a[ADC_BITS-1:0];
	endfunction

	// Sample driver.
	always @(posedge clk or negedge arst_n) begin
		sample_t s;
		if (!arst_n) begin
			sample_bus.valid <= 1'b0;
			sample_bus.adc_sample <= '0;
			sample_bus.motor_running <= 1'b0;
			tx_gap = 0;
		end else begin
			if (sample_bus.valid && sample_bus.ready) begin
				s = pending_samples.pop_front();
				expected_readings.push_back(gauge_step(s));
				tx_gap = tx_idle_off ? 0 : pick_gap();
			end
			if (tx_gap > 0) begin
				tx_gap--;
				sample_bus.valid <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				sample_bus.valid <= 1'b1;
				sample_bus.adc_sample <= pending_samples[0].adc;
				sample_bus.motor_running <= pending_samples[0].motor;
			end else begin
				sample_bus.valid <= 1'b0;
			end
		end
	end

	// Result monitor and ready control.
	always @(posedge clk or negedge arst_n) begin
		reading_t exp_r;
		if (!arst_n) begin
			level_bus.ready <= 1'b0;
			rx_gap = 0;
			rx_hold = 0;
		end else begin
			if (level_bus.valid && level_bus.ready) begin
				if (expected_readings.size() == 0) begin
					$error("result beat with no sample outstanding");
					failures++;
				end else begin
					exp_r = expected_readings.pop_front();
					if (level_bus.battery_level !== exp_r.level) begin
						$error("battery_level: expected %0d, got %0d", exp_r.level,
							level_bus.battery_level);
						failures++;
					end
					if (level_bus.low_power !== exp_r.low_power) begin
						$error("low_power: expected %0d, got %0d", exp_r.low_power,
							level_bus.low_power);
						failures++;
					end
					if (level_bus.low_warning !== exp_r.warning) begin
						$error("low_warning: expected %0d, got %0d", exp_r.warning,
							level_bus.low_warning);
						failures++;
					end
					if (level_bus.battery_voltage !== exp_r.volts) begin
						$error("battery_voltage: expected %0d, got %0d", exp_r.volts,
							level_bus.battery_voltage);
						failures++;
					end
				end
				rx_gap = rx_idle_off ? 0 : pick_gap();
			end
			if (hold_seen != hold_ticket) begin
				hold_seen = hold_ticket;
				rx_hold = HOLD_CYCLES;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				level_bus.ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				level_bus.ready <= 1'b0;
			end else begin
				level_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	task automatic write_reg(input blg_pkg::cfg_idx_t idx, input int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[blg_pkg::CFG_DATA_W-1:0];
		case (idx)
			blg_pkg::CFG_DEBOUNCE: gauge_debounce = value[blg_pkg::COUNT_W-1:0];
			blg_pkg::CFG_LOW_STOP: gauge_stop_thr = value[blg_pkg::VOLT_W-1:0];
			blg_pkg::CFG_LOW_RUN: gauge_run_thr = value[blg_pkg::VOLT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input int debounce, input int stop_thr, input int run_thr);
		write_reg(blg_pkg::CFG_DEBOUNCE, debounce);
		write_reg(blg_pkg::CFG_LOW_STOP, stop_thr);
		write_reg(blg_pkg::CFG_LOW_RUN, run_thr);
	endtask

	task automatic wait_drained();
		while (pending_samples.size() != 0 || expected_readings.size() != 0)
			@(posedge clk);
		repeat (LATENCY_PAD) @(posedge clk);
	endtask

	task automatic push_volts(input int volts, input logic motor, input int count);
		sample_t s;
		repeat (count) begin
			s.adc = adc_for(volts);
			s.motor = motor;
			pending_samples.push_back(s);
		end
	endtask

	task automatic push_raw(input int adc, input logic motor);
		sample_t s;
		s.adc = adc[ADC_BITS-1:0];
		s.motor = motor;
		pending_samples.push_back(s);
	endtask

	// Runs of similar samples so the debounce can commit, mixed with noise and extremes.
	task automatic queue_random(input int count);
		int run;
		int sel;
		int centre;
		logic motor;
		sample_t s;
		while (count > 0) begin
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 25) : $urandom_range(1, 12);
			motor = 1'($urandom_range(0, 1));
			sel = $urandom_range(0, 99);
			centre = $urandom_range(325, 400);
			repeat (run) begin
				if ($urandom_range(0, 19) == 0)
					motor = ~motor;
				s.motor = motor;
				if (sel < 70)
					s.adc = adc_for(centre + $urandom_range(0, 2) - 1);
				else if (sel < 85)
					s.adc = ADC_BITS'($urandom_range(0, FULL_SCALE));
				else
					case ($urandom_range(0, 3))
						0: s.adc = '0;
						1: s.adc = ADC_BITS'(FULL_SCALE);
						2: s.adc = ADC_BITS'($urandom_range(0, 15));
						default: s.adc = ADC_BITS'($urandom_range(FULL_SCALE - 15, FULL_SCALE));
					endcase
				pending_samples.push_back(s);
			end
			count -= run;
		end
	endtask

	initial begin
		int phase;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes of the reading, then both sides of every stopped-motor threshold and of the running steps at 380 and 345.
		push_raw(0, 1'b0);
		push_raw(FULL_SCALE, 1'b1);
		push_raw(FULL_SCALE, 1'b0);
		push_raw(1, 1'b1);
		push_raw(FULL_SCALE - 1, 1'b0);
		push_volts(391, 1'b0, 1);
		push_volts(390, 1'b0, 1);
		push_volts(386, 1'b0, 1);
		push_volts(385, 1'b0, 1);
		push_volts(371, 1'b0, 1);
		push_volts(370, 1'b0, 1);
		push_volts(361, 1'b0, 1);
		push_volts(360, 1'b0, 1);
		push_volts(380, 1'b1, 1);
		push_volts(379, 1'b1, 1);
		push_volts(356, 1'b0, 1);
		push_volts(355, 1'b0, 1);
		push_volts(351, 1'b0, 1);
		push_volts(350, 1'b0, 1);
		push_volts(346, 1'b1, 1);
		push_volts(345, 1'b1, 1);
		wait_drained();

		// Limit at its top: the repeat count saturates and nothing commits.
		set_config(15, MAX_VOLTS, 0);
		push_volts(300, 1'b0, 20);
		wait_drained();

		// Lowering the limit below the saturated count commits on the next repeat.
		write_reg(blg_pkg::CFG_DEBOUNCE, 2);
		push_volts(300, 1'b0, 6);
		wait_drained();

		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_config(0, 340, 335);
				1: set_config(1, 1023, 1023);
				2: set_config(7, 0, MAX_VOLTS);
				3: set_config(4, 350, 345);
				default: set_config($urandom_range(0, 15), $urandom_range(300, 400),
					$urandom_range(300, 400));
			endcase
			tx_idle_off = (phase == 2 || phase == 4);
			rx_idle_off = (phase == 4);
			// Back up the result side while the sample side keeps offering beats.
			if (phase == 2)
				hold_ticket++;
			queue_random(115);
			wait_drained();
		end

		if (failures == 0 && expected_readings.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

// File: files.f
sv/blg_pkg.sv
sv/blg_in_if.sv
sv/blg_out_if.sv
sv/blg_scale.sv
sv/blg_track.sv
sv/battery_level_gauge_top.sv
tb/sv/tb.sv
